[src/lcgj_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgj_pkg
// Shared types and constants for the LCG jump-ahead block.
// ----------------------------------------------------------------------------
package lcgj_pkg;

  localparam int SEED_BITS = 32;
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;
  localparam int HIGH_BITS = 16;

  typedef logic [SEED_BITS-1:0] seed_t;

  localparam seed_t MULT_RESET = seed_t'(32'd214013);
  localparam seed_t INCR_RESET = seed_t'(32'd2531011);

  // register select, taken from paddr[2]
  localparam logic REG_MULT = 1'b0;
  localparam logic REG_INCR = 1'b1;

  // operands of the shared multiply-add: y = a * b + addend
  typedef struct packed {
    seed_t a;
    seed_t b;
    seed_t addend;
  } mac_op_t;

endpackage

[src/lcgj_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgj_in_if / lcgj_out_if
// Valid/ready channels for jump requests and jump results.
// ----------------------------------------------------------------------------
interface lcgj_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_seed;
  logic [31:0] step_count;

  modport source (output valid, output start_seed, output step_count, input ready);
  modport sink   (input valid, input start_seed, input step_count, output ready);
endinterface

interface lcgj_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_seed;
  logic [15:0] high_bits;

  modport source (output valid, output next_seed, output high_bits, input ready);
  modport sink   (input valid, input next_seed, input high_bits, output ready);
endinterface

[src/lcg_jump_ahead.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_jump_ahead
// Skips an LCG x' = a*x + c ahead by n steps with square-and-multiply over
// the step count bits, one shared multiply-add doing every product.
// Sequence: per step-count bit up to the highest set bit, a block sum and a
//   block power update, with an accumulator sum and power update first for
//   each set bit, then a final multiply and multiply-add. Requests are taken
//   one at a time; ready is low until the result is loaded.
// A zero step count runs as 2^32 steps of the geometric sum.
// Reset (rst, synchronous) idles the sequencer, drops the output beat and
// loads the multiplier and increment reset values.
// ----------------------------------------------------------------------------
module lcg_jump_ahead (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcgj_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lcgj_pkg::DATA_BITS-1:0] pwdata,
  output logic [lcgj_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  lcgj_in_if.sink                        jump,
  lcgj_out_if.source                     result
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ACC_SUM = 3'd1;
  localparam logic [2:0] S_ACC_POW = 3'd2;
  localparam logic [2:0] S_BLK_SUM = 3'd3;
  localparam logic [2:0] S_BLK_POW = 3'd4;
  localparam logic [2:0] S_FIN_MUL = 3'd5;
  localparam logic [2:0] S_FIN_ADD = 3'd6;

  logic [2:0]      state;
  lcgj_pkg::seed_t mult;
  lcgj_pkg::seed_t incr;
  lcgj_pkg::seed_t seed;
  logic [32:0]     cnt;
  logic            zero;
  lcgj_pkg::seed_t acc_sum;
  lcgj_pkg::seed_t acc_pow;
  lcgj_pkg::seed_t blk_sum;
  lcgj_pkg::seed_t blk_pow;
  lcgj_pkg::seed_t res;
  logic            out_valid;
  logic [31:0]     out_seed;
  logic [15:0]     out_high;

  lcgj_pkg::mac_op_t mac_op;
  lcgj_pkg::seed_t   mac_y;
  logic              accept;
  logic              out_free;
  logic [32:0]     cnt_shift;
  logic              cfg_wr;

  lcgj_mac u_mac (
    .op (mac_op),
    .y  (mac_y)
  );

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == lcgj_pkg::REG_INCR) ? lcgj_pkg::DATA_BITS'(incr)
                                                   : lcgj_pkg::DATA_BITS'(mult);

  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= lcgj_pkg::MULT_RESET;
      incr <= lcgj_pkg::INCR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lcgj_pkg::REG_MULT) begin
        mult <= lcgj_pkg::seed_t'(pwdata);
      end else begin
        incr <= lcgj_pkg::seed_t'(pwdata);
      end
    end
  end

  // ---- handshakes
  assign jump.ready    = (state == S_IDLE);
  assign accept        = jump.valid && jump.ready;
  assign out_free      = !out_valid || result.ready;
  assign cnt_shift     = cnt >> 1;
  assign result.valid     = out_valid;
  assign result.next_seed = out_seed;
  assign result.high_bits = out_high;

  // ---- operand select for the shared multiply-add
  always_comb begin
    mac_op.a      = acc_pow;
    mac_op.b      = blk_sum;
    mac_op.addend = '0;
    case (state)
      S_ACC_SUM: begin
        mac_op.a      = acc_pow;
        mac_op.b      = blk_sum;
        mac_op.addend = acc_sum;
      end
      S_ACC_POW: begin
        mac_op.a = acc_pow;
        mac_op.b = blk_pow;
      end
      S_BLK_SUM: begin
        // blk_sum * (1 + blk_pow) = blk_sum * blk_pow + blk_sum
        mac_op.a      = blk_sum;
        mac_op.b      = blk_pow;
        mac_op.addend = blk_sum;
      end
      S_BLK_POW: begin
        mac_op.a = blk_pow;
        mac_op.b = blk_pow;
      end
      S_FIN_MUL: begin
        // a^0 is 1 for a zero step count, even though the sum ran 2^32 terms
        mac_op.a = seed;
        mac_op.b = zero ? lcgj_pkg::seed_t'(1) : acc_pow;
      end
      S_FIN_ADD: begin
        mac_op.a      = incr;
        mac_op.b      = acc_sum;
        mac_op.addend = res;
      end
      default: begin
        mac_op.a      = acc_pow;
        mac_op.b      = blk_sum;
        mac_op.addend = '0;
      end
    endcase
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN_ADD && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // a zero step count has bit 0 clear in the widened count too
          if (accept) begin
            state <= jump.step_count[0] ? S_ACC_SUM : S_BLK_SUM;
          end
        end
        S_ACC_SUM: state <= S_ACC_POW;
        S_ACC_POW: state <= S_BLK_SUM;
        S_BLK_SUM: state <= S_BLK_POW;
        S_BLK_POW: begin
          if (cnt_shift == '0) begin
            state <= S_FIN_MUL;
          end else if (cnt_shift[0]) begin
            state <= S_ACC_SUM;
          end else begin
            state <= S_BLK_SUM;
          end
        end
        S_FIN_MUL: state <= S_FIN_ADD;
        S_FIN_ADD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          seed    <= lcgj_pkg::seed_t'(jump.start_seed);
          zero    <= (jump.step_count == '0);
          cnt     <= {(jump.step_count == '0), jump.step_count};
          acc_sum <= '0;
          acc_pow <= lcgj_pkg::seed_t'(1);
          blk_sum <= lcgj_pkg::seed_t'(1);
          blk_pow <= mult;
        end
      end
      S_ACC_SUM: acc_sum <= mac_y;
      S_ACC_POW: acc_pow <= mac_y;
      S_BLK_SUM: blk_sum <= mac_y;
      S_BLK_POW: begin
        blk_pow <= mac_y;
        cnt     <= cnt_shift;
      end
      S_FIN_MUL: res <= mac_y;
      S_FIN_ADD: begin
        if (out_free) begin
          out_seed <= 32'(mac_y);
          out_high <= mac_y[lcgj_pkg::SEED_BITS-1 -: lcgj_pkg::HIGH_BITS];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/lcgj_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgj_mac
// Shared multiply-add, result kept modulo 2^SEED_BITS.
// ----------------------------------------------------------------------------
module lcgj_mac (
  input  lcgj_pkg::mac_op_t op,
  output lcgj_pkg::seed_t   y
);

  logic [2*lcgj_pkg::SEED_BITS-1:0] prod;

  always_comb begin
    prod = op.a * op.b;
    y    = prod[lcgj_pkg::SEED_BITS-1:0] + op.addend;
  end

endmodule

[src/lcgj_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgj_checker
// Port-level checks on the jump-ahead block, bound to the top level.
// ----------------------------------------------------------------------------
module lcgj_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           pready,
  input logic                           jump_valid,
  input logic                           jump_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [31:0]                    result_next_seed,
  input logic [15:0]                    result_high_bits
);

  // a waiting result beat is not withdrawn
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // one request at a time: ready drops after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    jump_valid && jump_ready |=> !jump_ready ##1 !jump_ready ##1 !jump_ready)
    else $error("request accepted while busy");

  // high_bits is the top of the state, which is next_seed at this width
  a_high_bits: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (lcgj_pkg::SEED_BITS != 32) ||
                     (result_high_bits == result_next_seed[31:16]))
    else $error("high_bits does not match next_seed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind lcg_jump_ahead lcgj_checker u_lcgj_checker (
  .clk              (clk),
  .rst              (rst),
  .pready           (pready),
  .jump_valid       (jump.valid),
  .jump_ready       (jump.ready),
  .result_valid     (result.valid),
  .result_ready     (result.ready),
  .result_next_seed (result.next_seed),
  .result_high_bits (result.high_bits)
);
